// ----- rtl/core/occupancy_grid_ray_update_unit_macros.svh -----
// assertion helpers used by ogru_back
`ifndef OCCUPANCY_GRID_RAY_UPDATE_UNIT_MACROS_SVH
`define OCCUPANCY_GRID_RAY_UPDATE_UNIT_MACROS_SVH

`ifndef ASSERT_OFF
// clocked check, disabled while reset is asserted
`define OGRU_ASSERT(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
	else $error("ogru assertion failed");
// clocked check that also holds through reset
`define OGRU_ASSERT_NR(label, clk, prop) \
	label: assert property (@(posedge clk) (prop)) \
	else $error("ogru assertion failed");
`else
`define OGRU_ASSERT(label, clk, rst_n, prop)
`define OGRU_ASSERT_NR(label, clk, prop)
`endif

`endif

// ----- rtl/core/ogru_pkg.sv -----
package ogru_pkg;

	localparam int POS_W = 16;
	localparam int N_W   = 16;
	localparam int ERR_W = 40;
	localparam int Q_W   = 13;
	localparam int D_W   = 18;
	localparam int RC_W  = 8;
	localparam int LO_W  = 16;
	localparam int LIM_W = 15;
	localparam int VIS_W = 12;

	typedef enum logic [1:0] {
		FUNC_RAY   = 2'd0,
		FUNC_READ  = 2'd1,
		FUNC_CLEAR = 2'd2
	} func_t;

	typedef enum logic [1:0] {
		CFG_PRIOR = 2'd0,
		CFG_OCC   = 2'd1,
		CFG_FREE  = 2'd2,
		CFG_LIMIT = 2'd3
	} cfg_idx_t;

	typedef struct packed {
		logic signed [LO_W-1:0] prior;
		logic signed [LO_W-1:0] occ;
		logic signed [LO_W-1:0] free;
		logic [LIM_W-1:0]       limit;
	} cfg_t;

	typedef struct packed {
		logic [1:0]              func;
		logic signed [POS_W-1:0] x;
		logic signed [POS_W-1:0] y;
		logic [D_W-1:0]          dx;
		logic [D_W-1:0]          dy;
		logic                    x_up;
		logic                    y_up;
		logic                    dx_nz;
		logic                    dy_nz;
		logic signed [ERR_W-1:0] err;
		logic [N_W-1:0]          n;
		logic [RC_W-1:0]         col;
		logic [RC_W-1:0]         row;
	} cmd_t;

	typedef struct packed {
		logic signed [LO_W-1:0] log_odds;
		logic                   status;
		logic [VIS_W-1:0]       visited;
	} res_t;

	typedef enum logic [2:0] {
		B_INIT,
		B_IDLE,
		B_CLEAR,
		B_RD_WAIT,
		B_RAY_CHK,
		B_DIV,
		B_RAY_WR,
		B_DONE
	} back_state_t;

endpackage

// ----- rtl/core/occupancy_grid_ray_update_unit.sv -----
// channel   direction  handshake            payload
// input     in         push / full          func, start_x, start_y, end_x, end_y,
//                                           read_col, read_row
// result    out        empty / pop          cell_log_odds, status, cells_visited
// config    in         cfg_valid/cfg_ready  cfg_index, cfg_data
//
// front setup is registered in stages s1 and s2, then items queue for the back end.
// ray: each cell inside the grid takes a read, an iterative divide and a write; an
// edge cell is only stepped over. read: one memory read. clear: every cell to the prior.
// after reset the grid is swept to the prior, full held high.
// full rises when the command queue backs up; a stalled pop holds the result queue.
module occupancy_grid_ray_update_unit #(
	parameter int GRID_SIZE = 256,
	parameter int FRAC_BITS = 8
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	output logic               full,
	input  logic [1:0]         func,
	input  logic [15:0]        start_x,
	input  logic [15:0]        start_y,
	input  logic signed [17:0] end_x,
	input  logic signed [17:0] end_y,
	input  logic [7:0]         read_col,
	input  logic [7:0]         read_row,
	output logic               empty,
	input  logic               pop,
	output logic signed [15:0] cell_log_odds,
	output logic               status,
	output logic [11:0]        cells_visited,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [1:0]         cfg_index,
	input  logic [15:0]        cfg_data
);
	import ogru_pkg::*;

	cfg_t cfg_q;
	cmd_t front_cmd, q_cmd;
	res_t back_res, out_res;
	logic front_full, init_busy, accept;
	logic cmd_push, cmd_full, cmd_empty, cmd_pop;
	logic res_push, res_full;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.prior <= 16'sd0;
			cfg_q.occ   <= 16'sd867;
			cfg_q.free  <= -16'sd867;
			cfg_q.limit <= 15'd4096;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_idx_t'(cfg_index))
				CFG_PRIOR: cfg_q.prior <= cfg_data;
				CFG_OCC:   cfg_q.occ   <= cfg_data;
				CFG_FREE:  cfg_q.free  <= cfg_data;
				CFG_LIMIT: cfg_q.limit <= cfg_data[LIM_W-1:0];
				default: begin
				end
			endcase
		end
	end

	assign full   = front_full || init_busy;
	assign accept = push && !full;

	ogru_front #(
		.FRAC_BITS(FRAC_BITS)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.func      (func),
		.start_x   (start_x),
		.start_y   (start_y),
		.end_x     (end_x),
		.end_y     (end_y),
		.read_col  (read_col),
		.read_row  (read_row),
		.front_full(front_full),
		.cmd       (front_cmd),
		.cmd_push  (cmd_push),
		.cmd_full  (cmd_full)
	);

	ogru_fifo #(
		.T    (cmd_t),
		.DEPTH(2)
	) u_cmd_q (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (cmd_push),
		.din   (front_cmd),
		.full  (cmd_full),
		.pop   (cmd_pop),
		.dout  (q_cmd),
		.empty (cmd_empty)
	);

	ogru_back #(
		.GRID_SIZE(GRID_SIZE),
		.FRAC_BITS(FRAC_BITS)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.cmd      (q_cmd),
		.cmd_empty(cmd_empty),
		.cmd_pop  (cmd_pop),
		.res      (back_res),
		.res_push (res_push),
		.res_full (res_full),
		.init_busy(init_busy)
	);

	ogru_fifo #(
		.T    (res_t),
		.DEPTH(2)
	) u_res_q (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (res_push),
		.din   (back_res),
		.full  (res_full),
		.pop   (pop),
		.dout  (out_res),
		.empty (empty)
	);

	assign cell_log_odds = out_res.log_odds;
	assign status        = out_res.status;
	assign cells_visited = out_res.visited;
endmodule

// ----- rtl/core/ogru_fifo.sv -----
module ogru_fifo #(
	parameter type T = logic,
	parameter int DEPTH = 2
) (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  T     din,
	output logic full,
	input  logic pop,
	output T     dout,
	output logic empty
);
	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	T               mem_q [DEPTH];
	logic [PW-1:0]  wr_ptr_q;
	logic [PW-1:0]  rd_ptr_q;
	logic [CNT_W-1:0] cnt_q;
	logic           do_push;
	logic           do_pop;

	assign full    = (cnt_q == CNT_W'(DEPTH));
	assign empty   = (cnt_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign dout    = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= din;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - CNT_W'(1);
			end
		end
	end
endmodule

// ----- rtl/core/ogru_front.sv -----
module ogru_front #(
	parameter int FRAC_BITS = 8
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               accept,
	input  logic [1:0]         func,
	input  logic [15:0]        start_x,
	input  logic [15:0]        start_y,
	input  logic signed [17:0] end_x,
	input  logic signed [17:0] end_y,
	input  logic [7:0]         read_col,
	input  logic [7:0]         read_row,
	output logic               front_full,
	output ogru_pkg::cmd_t     cmd,
	output logic               cmd_push,
	input  logic               cmd_full
);
	import ogru_pkg::*;

	localparam int FW  = FRAC_BITS + 1;
	localparam int ONE = 1 << FRAC_BITS;
	localparam int PW  = FW + D_W;

	// per-axis setup
	logic signed [18:0] x0e, x1e, xdiff, xneg, xc, xfl, xspan;
	logic signed [18:0] y0e, y1e, ydiff, yneg, yc, yfl, yspan;
	logic               xgt, ygt;
	logic [FW-1:0]      xfa, yfa;

	// stage 1
	logic               v_s1;
	logic [1:0]         func_s1;
	logic [RC_W-1:0]    col_s1, row_s1;
	logic signed [POS_W-1:0] xc_s1, yc_s1;
	logic [D_W-1:0]     dx_s1, dy_s1;
	logic               xgt_s1, ygt_s1;
	logic [N_W-1:0]     xspan_s1, yspan_s1;
	logic [FW-1:0]      xfa_s1, yfa_s1;

	// stage 2
	logic               v_s2;
	logic [1:0]         func_s2;
	logic [RC_W-1:0]    col_s2, row_s2;
	logic signed [POS_W-1:0] xc_s2, yc_s2;
	logic [D_W-1:0]     dx_s2, dy_s2;
	logic               xgt_s2, ygt_s2;
	logic [N_W-1:0]     n_s2;
	logic [PW-1:0]      ex_s2, ey_s2;

	logic adv;

	always_comb begin
		x0e   = {3'b000, start_x};
		x1e   = {end_x[17], end_x};
		xgt   = x1e > x0e;
		xdiff = x1e - x0e;
		xneg  = -xdiff;
		xc    = x0e >>> FRAC_BITS;
		xfl   = x1e >>> FRAC_BITS;
		xspan = xgt ? (xfl - xc) : (xc - xfl);
		xfa   = xgt ? (FW'(ONE) - {1'b0, start_x[FRAC_BITS-1:0]})
		            : {1'b0, start_x[FRAC_BITS-1:0]};

		y0e   = {3'b000, start_y};
		y1e   = {end_y[17], end_y};
		ygt   = y1e > y0e;
		ydiff = y1e - y0e;
		yneg  = -ydiff;
		yc    = y0e >>> FRAC_BITS;
		yfl   = y1e >>> FRAC_BITS;
		yspan = ygt ? (yfl - yc) : (yc - yfl);
		yfa   = ygt ? (FW'(ONE) - {1'b0, start_y[FRAC_BITS-1:0]})
		            : {1'b0, start_y[FRAC_BITS-1:0]};
	end

	assign cmd_push   = v_s2 && !cmd_full;
	assign adv        = !v_s2 || !cmd_full;
	assign front_full = !adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else if (adv) begin
			v_s1 <= accept;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			func_s1  <= func;
			col_s1   <= read_col;
			row_s1   <= read_row;
			xc_s1    <= xc[POS_W-1:0];
			yc_s1    <= yc[POS_W-1:0];
			dx_s1    <= xgt ? xdiff[D_W-1:0] : xneg[D_W-1:0];
			dy_s1    <= ygt ? ydiff[D_W-1:0] : yneg[D_W-1:0];
			xgt_s1   <= xgt;
			ygt_s1   <= ygt;
			xspan_s1 <= xspan[N_W-1:0];
			yspan_s1 <= yspan[N_W-1:0];
			xfa_s1   <= xfa;
			yfa_s1   <= yfa;

			func_s2  <= func_s1;
			col_s2   <= col_s1;
			row_s2   <= row_s1;
			xc_s2    <= xc_s1;
			yc_s2    <= yc_s1;
			dx_s2    <= dx_s1;
			dy_s2    <= dy_s1;
			xgt_s2   <= xgt_s1;
			ygt_s2   <= ygt_s1;
			n_s2     <= N_W'(1) + ((dx_s1 != '0) ? xspan_s1 : '0)
			                    + ((dy_s1 != '0) ? yspan_s1 : '0);
			ex_s2    <= (dx_s1 != '0) ? PW'(xfa_s1) * PW'(dy_s1) : '0;
			ey_s2    <= (dy_s1 != '0) ? PW'(yfa_s1) * PW'(dx_s1) : '0;
		end
	end

	always_comb begin
		cmd.func  = func_s2;
		cmd.x     = xc_s2;
		cmd.y     = yc_s2;
		cmd.dx    = dx_s2;
		cmd.dy    = dy_s2;
		cmd.x_up  = xgt_s2;
		cmd.y_up  = ygt_s2;
		cmd.dx_nz = dx_s2 != '0;
		cmd.dy_nz = dy_s2 != '0;
		cmd.err   = $signed(ERR_W'(ex_s2)) - $signed(ERR_W'(ey_s2));
		cmd.n     = n_s2;
		cmd.col   = col_s2;
		cmd.row   = row_s2;
	end
endmodule

// ----- rtl/core/ogru_div.sv -----
module ogru_div #(
	parameter int DVD_W = 28,
	parameter int DIV_W = 20
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	input  logic [DVD_W-1:0]        dividend,
	input  logic [DIV_W-1:0]        divisor,
	output logic                    done,
	output logic [ogru_pkg::Q_W-1:0] quot
);
	import ogru_pkg::*;

	localparam int SH_W  = DIV_W + Q_W - 1;
	localparam int MW    = (DVD_W > SH_W) ? DVD_W : SH_W;
	localparam int CNT_W = $clog2(Q_W + 1);

	logic [DVD_W-1:0] rem_q;
	logic [SH_W-1:0]  dsh_q;
	logic [Q_W-1:0]   quot_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;
	logic             ge;
	logic [MW-1:0]    diff;

	assign ge   = MW'(rem_q) >= MW'(dsh_q);
	assign diff = MW'(rem_q) - MW'(dsh_q);
	assign done = done_q;
	assign quot = quot_q;

	// one quotient bit per cycle while busy, msb first
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q  <= dividend;
			dsh_q  <= SH_W'(divisor) << (Q_W - 1);
			quot_q <= '0;
		end else if (busy_q) begin
			if (ge) begin
				rem_q <= diff[DVD_W-1:0];
			end
			quot_q <= {quot_q[Q_W-2:0], ge};
			dsh_q  <= dsh_q >> 1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				cnt_q  <= CNT_W'(Q_W);
				busy_q <= 1'b1;
			end else if (busy_q) begin
				cnt_q <= cnt_q - CNT_W'(1);
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end
endmodule

// ----- rtl/core/ogru_back.sv -----
`include "occupancy_grid_ray_update_unit_macros.svh"

module ogru_back #(
	parameter int GRID_SIZE = 256,
	parameter int FRAC_BITS = 8
) (
	input  logic           clk,
	input  logic           arst_n,
	input  ogru_pkg::cfg_t cfg,
	input  ogru_pkg::cmd_t cmd,
	input  logic           cmd_empty,
	output logic           cmd_pop,
	output ogru_pkg::res_t res,
	output logic           res_push,
	input  logic           res_full,
	output logic           init_busy
);
	import ogru_pkg::*;

	localparam int CELLS  = GRID_SIZE * GRID_SIZE;
	localparam int ADDR_W = $clog2(CELLS);
	localparam int CW     = $clog2(GRID_SIZE);
	localparam int DVD_W  = LO_W + 1 + $clog2(GRID_SIZE + 1);
	localparam int DIV_W  = N_W + 4;
	localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(CELLS - 1);
	localparam logic signed [POS_W-1:0] G_POS = POS_W'(GRID_SIZE);

	logic signed [LO_W-1:0] mem [CELLS];
	logic signed [LO_W-1:0] rd_q;

	back_state_t             state_q, state_d;
	cmd_t                    cmd_q;
	logic signed [POS_W-1:0] x_q, y_q, x_n, y_n;
	logic signed [ERR_W-1:0] err_q, err_n;
	logic [N_W-1:0]          k_q;
	logic [ADDR_W-1:0]       sweep_q;
	res_t                    res_q;

	logic                    mem_we, mem_re;
	logic [ADDR_W-1:0]       waddr, raddr, cell_addr, read_addr;
	logic signed [LO_W-1:0]  wdata;

	logic                    in_grid, oob, last, step_y, rd_in, ray_end;
	logic signed [LO_W-1:0]  lsel;
	logic [LO_W:0]           l17, lmag;
	logic                    div_start, div_done;
	logic [DVD_W-1:0]        dvd;
	logic [DIV_W-1:0]        dvs;
	logic [Q_W-1:0]          div_quot;
	logic signed [Q_W:0]     wpos, w;
	logic signed [LO_W+1:0]  v, lim_pos, lim_neg, vc;

	ogru_div #(
		.DVD_W(DVD_W),
		.DIV_W(DIV_W)
	) u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (div_start),
		.dividend(dvd),
		.divisor (dvs),
		.done    (div_done),
		.quot    (div_quot)
	);

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[waddr] <= wdata;
		end
		if (mem_re) begin
			rd_q <= mem[raddr];
		end
	end

	always_comb begin
		in_grid = (x_q > 0) && (x_q < G_POS) && (y_q > 0) && (y_q < G_POS);
		oob     = (x_q < 0) || (x_q > G_POS) || (y_q < 0) || (y_q > G_POS);
		ray_end = k_q == cmd_q.n;
		last    = ({1'b0, k_q} + (N_W+1)'(1)) == {1'b0, cmd_q.n};
		cell_addr = ADDR_W'(y_q[CW-1:0]) * ADDR_W'(GRID_SIZE) + ADDR_W'(x_q[CW-1:0]);
		read_addr = ADDR_W'(cmd.row) * ADDR_W'(GRID_SIZE) + ADDR_W'(cmd.col);
		rd_in   = (32'(cmd.col) < GRID_SIZE) && (32'(cmd.row) < GRID_SIZE);

		// weight = l * G / (8 * (G + k)), truncated toward zero
		lsel = last ? cfg.occ : cfg.free;
		l17  = {lsel[LO_W-1], lsel};
		lmag = lsel[LO_W-1] ? (LO_W+1)'(-l17) : l17;
		dvd  = DVD_W'(lmag) * DVD_W'(GRID_SIZE);
		dvs  = DIV_W'({1'b0, k_q} + (N_W+1)'(GRID_SIZE)) << 3;
		wpos = $signed({1'b0, div_quot});
		w    = lsel[LO_W-1] ? -wpos : wpos;

		v = $signed({{2{rd_q[LO_W-1]}}, rd_q})
		  + $signed({{(LO_W+1-Q_W){w[Q_W]}}, w})
		  - $signed({{2{cfg.prior[LO_W-1]}}, cfg.prior});
		lim_pos = $signed({3'b000, cfg.limit});
		lim_neg = -lim_pos;
		if (v < lim_neg) begin
			vc = lim_neg;
		end else if (v > lim_pos) begin
			vc = lim_pos;
		end else begin
			vc = v;
		end

		step_y = !cmd_q.dx_nz || (cmd_q.dy_nz && (err_q > 0));
		if (step_y) begin
			x_n   = x_q;
			y_n   = cmd_q.y_up ? y_q + POS_W'(1) : y_q - POS_W'(1);
			err_n = err_q - $signed(ERR_W'(cmd_q.dx) << FRAC_BITS);
		end else begin
			x_n   = cmd_q.x_up ? x_q + POS_W'(1) : x_q - POS_W'(1);
			y_n   = y_q;
			err_n = err_q + $signed(ERR_W'(cmd_q.dy) << FRAC_BITS);
		end
	end

	always_comb begin
		state_d   = state_q;
		cmd_pop   = 1'b0;
		mem_we    = 1'b0;
		mem_re    = 1'b0;
		waddr     = cell_addr;
		raddr     = cell_addr;
		wdata     = vc[LO_W-1:0];
		div_start = 1'b0;
		res_push  = 1'b0;
		unique case (state_q)
			B_INIT, B_CLEAR: begin
				mem_we = 1'b1;
				waddr  = sweep_q;
				wdata  = cfg.prior;
				if (sweep_q == LAST_ADDR) begin
					state_d = (state_q == B_INIT) ? B_IDLE : B_DONE;
				end
			end
			B_IDLE: begin
				if (!cmd_empty) begin
					cmd_pop = 1'b1;
					unique case (cmd.func)
						FUNC_RAY:   state_d = B_RAY_CHK;
						FUNC_CLEAR: state_d = B_CLEAR;
						FUNC_READ: begin
							if (rd_in) begin
								mem_re  = 1'b1;
								raddr   = read_addr;
								state_d = B_RD_WAIT;
							end else begin
								state_d = B_DONE;
							end
						end
						default:    state_d = B_DONE;
					endcase
				end
			end
			B_RD_WAIT: state_d = B_DONE;
			B_RAY_CHK: begin
				if (ray_end || oob) begin
					state_d = B_DONE;
				end else if (in_grid) begin
					mem_re    = 1'b1;
					div_start = 1'b1;
					state_d   = B_DIV;
				end
			end
			B_DIV: begin
				if (div_done) begin
					state_d = B_RAY_WR;
				end
			end
			B_RAY_WR: begin
				mem_we  = 1'b1;
				state_d = B_RAY_CHK;
			end
			B_DONE: begin
				if (!res_full) begin
					res_push = 1'b1;
					state_d  = B_IDLE;
				end
			end
			default: state_d = B_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= B_INIT;
			sweep_q <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == B_INIT || state_q == B_CLEAR) begin
				sweep_q <= sweep_q + ADDR_W'(1);
			end else begin
				sweep_q <= '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			B_IDLE: begin
				if (!cmd_empty) begin
					cmd_q <= cmd;
					x_q   <= cmd.x;
					y_q   <= cmd.y;
					err_q <= cmd.err;
					k_q   <= '0;
					res_q <= '0;
				end
			end
			B_RD_WAIT: res_q.log_odds <= rd_q;
			B_RAY_CHK: begin
				if (ray_end) begin
					res_q.visited <= cmd_q.n[VIS_W-1:0];
				end else if (oob) begin
					res_q.status  <= 1'b1;
					res_q.visited <= k_q[VIS_W-1:0];
				end else if (!in_grid) begin
					x_q   <= x_n;
					y_q   <= y_n;
					err_q <= err_n;
					k_q   <= k_q + N_W'(1);
				end
			end
			B_RAY_WR: begin
				x_q   <= x_n;
				y_q   <= y_n;
				err_q <= err_n;
				k_q   <= k_q + N_W'(1);
			end
			default: begin
			end
		endcase
	end

	assign res       = res_q;
	assign init_busy = state_q == B_INIT;

	`OGRU_ASSERT(a_push_has_space, clk, arst_n, res_push |-> !res_full)
	`OGRU_ASSERT(a_step_bound, clk, arst_n, (state_q == B_RAY_CHK) |-> (k_q <= cmd_q.n))
	`OGRU_ASSERT(a_quot_range, clk, arst_n, (state_q == B_RAY_WR) |-> (div_quot <= Q_W'(4096)))
	`OGRU_ASSERT_NR(a_wr_after_div, clk, (state_q == B_RAY_WR) |-> $past(state_q == B_DIV))
endmodule

// ----- bench/occupancy_grid_ray_update_checker.sv -----
module occupancy_grid_ray_update_checker (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  logic               full,
	input  logic [1:0]         func,
	input  logic [15:0]        start_x,
	input  logic [15:0]        start_y,
	input  logic signed [17:0] end_x,
	input  logic signed [17:0] end_y,
	input  logic [7:0]         read_col,
	input  logic [7:0]         read_row,
	input  logic               empty,
	input  logic               pop,
	input  logic signed [15:0] cell_log_odds,
	input  logic               status,
	input  logic [11:0]        cells_visited,
	input  logic               cfg_valid,
	input  logic               cfg_ready,
	input  logic [1:0]         cfg_index,
	input  logic [15:0]        cfg_data,
	output int                 fail_count,
	output int                 pending
);
	timeunit 1ns;
	timeprecision 1ps;

	import ogru_pkg::*;

	localparam int SIZE = 256;
	localparam int FB   = 8;

	logic signed [15:0] grid_mem [0:SIZE*SIZE-1];
	longint prior_lo, occ_lo, free_lo, limit_lo;
	res_t expected_results [$];

	function automatic void fill_grid();
		for (int i = 0; i < SIZE*SIZE; i++)
			grid_mem[i] = prior_lo[15:0];
	endfunction

	function automatic void bump_cell(longint x, longint y, longint l, longint k);
		longint w;
		longint v;
		if (x <= 0 || x >= SIZE || y <= 0 || y >= SIZE)
			return;
		w = (l * SIZE) / (8 * (SIZE + k));
		v = longint'(grid_mem[y*SIZE + x]) + w - prior_lo;
		if (v < -limit_lo) v = -limit_lo;
		if (v > limit_lo) v = limit_lo;
		grid_mem[y*SIZE + x] = v[15:0];
	endfunction

	function automatic res_t trace_ray(logic [15:0] sx, logic [15:0] sy,
		logic signed [17:0] ex, logic signed [17:0] ey);
		res_t r;
		longint one, fmask, x0, y0, x1, y1, dx, dy, x, y, n, err, xi, yi;
		logic step_y;
		one = longint'(1) << FB;
		fmask = one - 1;
		x0 = longint'(sx);
		y0 = longint'(sy);
		x1 = longint'(ex);
		y1 = longint'(ey);
		dx = x1 > x0 ? x1 - x0 : x0 - x1;
		dy = y1 > y0 ? y1 - y0 : y0 - y1;
		x = x0 >>> FB;
		y = y0 >>> FB;
		n = 1;
		err = 0;
		xi = 0;
		yi = 0;
		r = '0;
		// arithmetic shift of a signed value is a floor
		if (dx != 0) begin
			if (x1 > x0) begin
				xi = 1; n += (x1 >>> FB) - x; err = (one - (x0 & fmask)) * dy;
			end else begin
				xi = -1; n += x - (x1 >>> FB); err = (x0 & fmask) * dy;
			end
		end
		if (dy != 0) begin
			if (y1 > y0) begin
				yi = 1; n += (y1 >>> FB) - y; err -= (one - (y0 & fmask)) * dx;
			end else begin
				yi = -1; n += y - (y1 >>> FB); err -= (y0 & fmask) * dx;
			end
		end
		for (longint k = 0; k < n; k++) begin
			if (x < 0 || x > SIZE || y < 0 || y > SIZE) begin
				r.status = 1'b1;
				r.visited = k[11:0];
				return r;
			end
			bump_cell(x, y, (k == n - 1) ? occ_lo : free_lo, k);
			if (dx == 0) step_y = 1'b1;
			else if (dy == 0) step_y = 1'b0;
			else step_y = err > 0;
			if (step_y) begin
				y += yi; err -= dx * one;
			end else begin
				x += xi; err += dy * one;
			end
		end
		r.visited = n[11:0];
		return r;
	endfunction

	function automatic res_t predict_item();
		res_t r;
		r = '0;
		case (func)
			FUNC_RAY:   r = trace_ray(start_x, start_y, end_x, end_y);
			FUNC_READ:  r.log_odds = grid_mem[int'(read_row)*SIZE + int'(read_col)];
			FUNC_CLEAR: fill_grid();
			default: ;
		endcase
		return r;
	endfunction

	initial begin
		fail_count = 0;
		prior_lo = 0;
		occ_lo = 867;
		free_lo = -867;
		limit_lo = 4096;
		fill_grid();
	end

	assign pending = expected_results.size();

	always @(posedge clk) begin
		res_t want;
		if (arst_n) begin
			if (!empty && pop) begin
				if (expected_results.size() == 0) begin
					$error("result transaction with nothing expected");
					fail_count++;
				end else begin
					want = expected_results.pop_front();
					if (cell_log_odds !== want.log_odds) begin
						$error("cell_log_odds expected %0d actual %0d", want.log_odds,
							cell_log_odds);
						fail_count++;
					end
					if (status !== want.status) begin
						$error("status expected %0d actual %0d", want.status, status);
						fail_count++;
					end
					if (cells_visited !== want.visited) begin
						$error("cells_visited expected %0d actual %0d",
							want.visited, cells_visited);
						fail_count++;
					end
				end
			end
			if (push && !full)
				expected_results.push_back(predict_item());
			if (cfg_valid && cfg_ready) begin
				case (cfg_idx_t'(cfg_index))
					CFG_PRIOR: prior_lo = longint'($signed(cfg_data));
					CFG_OCC:   occ_lo = longint'($signed(cfg_data));
					CFG_FREE:  free_lo = longint'($signed(cfg_data));
					CFG_LIMIT: limit_lo = longint'(cfg_data[14:0]);
					default: ;
				endcase
			end
		end
	end

endmodule

// ----- bench/tb_occupancy_grid_ray_update_unit.sv -----
module tb_occupancy_grid_ray_update_unit;
	timeunit 1ns;
	timeprecision 1ps;
	import ogru_pkg::*;

	localparam logic [1:0] FUNC_NONE = 2'd3;

	logic               clk;
	logic               arst_n;
	logic               push;
	logic               full;
	logic [1:0]         func;
	logic [15:0]        start_x;
	logic [15:0]        start_y;
	logic signed [17:0] end_x;
	logic signed [17:0] end_y;
	logic [7:0]         read_col;
	logic [7:0]         read_row;
	logic               empty;
	logic               pop;
	logic signed [15:0] cell_log_odds;
	logic               status;
	logic [11:0]        cells_visited;
	logic               cfg_valid;
	logic               cfg_ready;
	logic [1:0]         cfg_index;
	logic [15:0]        cfg_data;
	int                 fail_count;
	int                 pending;

	bit gaps_on;
	bit hold_req;
	int last_col;
	int last_row;

	occupancy_grid_ray_update_unit dut (.*);

	occupancy_grid_ray_update_checker checker_i (.*);

	always begin
		clk = 1'b0;
		#2;
		clk = 1'b1;
		#2;
	end

	initial begin
		#40_000_000;
		$display("occupancy_grid_ray_update_unit regression: fail");
		$finish;
	end

	// result side: random pop stalls, plus one long hold-off on request
	initial begin
		pop <= 1'b0;
		wait (arst_n);
		forever begin
			if (hold_req) begin
				hold_req = 1'b0;
				pop <= 1'b0;
				repeat (400) @(posedge clk);
			end else if (gaps_on && $urandom_range(0, 2) == 0) begin
				pop <= 1'b0;
				repeat ($urandom_range(1, 17)) @(posedge clk);
			end else begin
				pop <= 1'b1;
				repeat ($urandom_range(1, 30)) @(posedge clk);
			end
		end
	end

	task automatic send_item(logic [1:0] f, logic [15:0] sx, logic [15:0] sy,
		logic signed [17:0] ex, logic signed [17:0] ey, logic [7:0] rc, logic [7:0] rr);
		func <= f;
		start_x <= sx;
		start_y <= sy;
		end_x <= ex;
		end_y <= ey;
		read_col <= rc;
		read_row <= rr;
		push <= 1'b1;
		do @(posedge clk); while (full);
		if (f == FUNC_RAY) begin
			last_col = int'(sx[15:8]);
			last_row = int'(sy[15:8]);
		end
		if (gaps_on && $urandom_range(0, 3) == 0) begin
			push <= 1'b0;
			repeat ($urandom_range(1, 17)) @(posedge clk);
		end
	endtask

	task automatic ray(int sx, int sy, int ex, int ey);
		send_item(FUNC_RAY, sx[15:0], sy[15:0], ex[17:0], ey[17:0],
			8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
	endtask

	task automatic read_cell(int c, int r);
		send_item(FUNC_READ, 16'($urandom), 16'($urandom), 18'($urandom), 18'($urandom),
			c[7:0], r[7:0]);
	endtask

	task automatic drain();
		push <= 1'b0;
		wait (pending == 0);
		repeat (40) @(posedge clk);
	endtask

	task automatic write_regs(logic [15:0] pr, logic [15:0] oc, logic [15:0] fr,
		logic [15:0] lim);
		logic [15:0] vals [4];
		vals = '{pr, oc, fr, lim};
		for (int i = 0; i < 4; i++) begin
			cfg_index <= cfg_idx_t'(i);
			cfg_data <= vals[i];
			cfg_valid <= 1'b1;
			do @(posedge clk); while (!cfg_ready);
		end
		cfg_valid <= 1'b0;
	endtask

	function automatic int near(int v, int span);
		return v + $urandom_range(0, 2*span) - span;
	endfunction

	task automatic random_item();
		int sel, sx, sy, ex, ey, len, c, r;
		sel = $urandom_range(0, 99);
		sx = $urandom_range(0, 65535);
		sy = $urandom_range(0, 65535);
		len = $urandom_range(0, 12) * 256 + $urandom_range(0, 255);
		ex = near(sx, len);
		ey = near(sy, len);
		if (sel < 58) begin
			case ($urandom_range(0, 9))
				6: ex = sx;
				7: ey = sy;
				8: begin
					ex = $signed($urandom_range(0, 262143) << 14) >>> 14;
					ey = $signed($urandom_range(0, 262143) << 14) >>> 14;
				end
				9: ex = -$urandom_range(1, 4096);
				default: ;
			endcase
			ray(sx, sy, ex, ey);
		end else if (sel < 88) begin
			c = near(last_col, 3);
			r = near(last_row, 3);
			if ($urandom_range(0, 4) == 0) begin
				c = $urandom_range(0, 255);
				r = $urandom_range(0, 255);
			end
			read_cell(c < 0 ? 0 : c > 255 ? 255 : c, r < 0 ? 0 : r > 255 ? 255 : r);
		end else if (sel < 91) begin
			send_item(FUNC_CLEAR, 16'($urandom), 16'($urandom), 18'($urandom),
				18'($urandom), 8'($urandom), 8'($urandom));
		end else begin
			send_item(FUNC_NONE, 16'($urandom), 16'($urandom), 18'($urandom),
				18'($urandom), 8'($urandom), 8'($urandom));
		end
	endtask

	task automatic random_phase(int count);
		send_item(FUNC_CLEAR, '0, '0, '0, '0, '0, '0);
		repeat (count) random_item();
		drain();
	endtask

	initial begin
		arst_n = 1'b0;
		gaps_on = 1'b1;
		hold_req = 1'b0;
		last_col = 128;
		last_row = 128;
		push <= 1'b0;
		func <= FUNC_RAY;
		start_x <= '0;
		start_y <= '0;
		end_x <= '0;
		end_y <= '0;
		read_col <= '0;
		read_row <= '0;
		cfg_valid <= 1'b0;
		cfg_index <= CFG_PRIOR;
		cfg_data <= '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed part under reset settings
		read_cell(0, 0);
		read_cell(255, 255);
		send_item(FUNC_NONE, 16'hffff, 16'hffff, '1, '1, 8'hff, 8'hff);
		ray(10*256 + 128, 20*256 + 64, 10*256 + 128, 30*256);
		ray(40*256, 50*256 + 200, 30*256 + 5, 50*256 + 7);
		ray(60*256 + 17, 60*256 + 99, 70*256 + 3, 75*256 + 250);
		ray(90*256 + 200, 90*256 + 10, 80*256 + 1, 85*256 + 128);
		ray(100*256, 100*256, 100*256, 100*256);
		ray(0, 0, 5*256, 3*256);
		ray(65535, 65535, 131071, 131071);
		ray(65535, 100, -131072, -131072);
		ray(3*256, 3*256, -2*256, 4*256);
		ray(120*256, 2*256, 120*256, -600);
		read_cell(10, 25);
		read_cell(35, 50);
		read_cell(65, 67);
		read_cell(85, 87);
		read_cell(100, 100);
		read_cell(1, 1);
		read_cell(255, 0);
		send_item(FUNC_CLEAR, '0, '0, '0, '0, '0, '0);
		read_cell(10, 25);
		drain();

		random_phase(20);

		write_regs(16'h8000, 16'h7fff, 16'h8000, 16'h7fff);
		random_phase(20);

		// long pop hold-off while items keep arriving
		write_regs(16'h7fff, 16'h8000, 16'h7fff, 16'h0000);
		hold_req = 1'b1;
		repeat (25) read_cell($urandom_range(0, 255), $urandom_range(0, 255));
		random_phase(15);

		write_regs(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
		random_phase(20);

		gaps_on = 1'b0;
		write_regs(16'd100, 16'd1500, -16'sd400, 16'd2000);
		random_phase(20);

		if (fail_count == 0 && pending == 0)
			$display("occupancy_grid_ray_update_unit regression: pass");
		else
			$display("occupancy_grid_ray_update_unit regression: fail");
		$finish;
	end

endmodule

// ----- sim.f -----
+incdir+rtl/core
rtl/core/ogru_pkg.sv
rtl/core/ogru_fifo.sv
rtl/core/ogru_front.sv
rtl/core/ogru_div.sv
rtl/core/ogru_back.sv
rtl/core/occupancy_grid_ray_update_unit.sv
bench/occupancy_grid_ray_update_checker.sv
bench/tb_occupancy_grid_ray_update_unit.sv
